// File: rtl/lvr_pkg.sv
package lvr_pkg;

    localparam int WEIGHT_W         = 17;
    localparam int OFFSET_W         = 10;
    localparam int INDEX_W          = 6;
    localparam int PARTICLE_CNT_DEF = 64;
    localparam int Q16_ONE          = 65536;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_WALK
    } t_state;

endpackage

// File: rtl/lvr_in_if.sv
interface lvr_in_if
    import lvr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0] start_offset;

    modport source (output valid, weight, start_offset, input ready);
    modport sink   (input valid, weight, start_offset, output ready);
endinterface

// File: rtl/lvr_out_if.sv
interface lvr_out_if
    import lvr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] chosen_index;
    logic               final_pick;

    modport source (output valid, chosen_index, final_pick, input ready);
    modport sink   (input valid, chosen_index, final_pick, output ready);
endinterface

// File: rtl/low_variance_resampler.sv
// Weights load at one request per cycle while the walker is in its load state.
// After the final weight, a prime state fetches weight 0 into the running sum;
// then each walk step either advances the index or emits a pick, and the
// first pick comes from the walk state that follows the prime state;
// the output register lets the walk run on while a pick waits. Synchronous
// active-low reset clears the sequencer and load count; the weight memory is not cleared.
module low_variance_resampler
    import lvr_pkg::*;
#(
    parameter int PARTICLE_CNT = PARTICLE_CNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lvr_in_if.sink    i_in,
    lvr_out_if.source o_out
);

    localparam int IDX_W = $clog2(PARTICLE_CNT);

    logic                emit_valid;
    logic                emit_ok;
    logic [IDX_W-1:0]    emit_index;
    logic                emit_last;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WEIGHT_W-1:0] mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [WEIGHT_W-1:0] mem_rdata;

    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_last;

    assign emit_ok = !r_out_valid || o_out.ready;

    lvr_walker #(
        .PARTICLE_CNT (PARTICLE_CNT),
        .IDX_W        (IDX_W)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_weight     (i_in.weight),
        .i_offset     (i_in.start_offset),
        .o_emit_valid (emit_valid),
        .i_emit_ok    (emit_ok),
        .o_emit_index (emit_index),
        .o_emit_last  (emit_last),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    lvr_weight_mem #(
        .DEPTH  (PARTICLE_CNT),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid && emit_ok) begin
            r_out_index <= INDEX_W'(emit_index);
            r_out_last  <= emit_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.chosen_index = r_out_index;
    assign o_out.final_pick   = r_out_last;

    // no weight is taken while the walk is emitting
    a_no_load_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_valid |-> !i_in.ready)
        else $error("weight request accepted during walk");

    // a blocked pick holds until the output register frees up
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_valid && !emit_ok |=> emit_valid && $stable(emit_index)
            && $stable(emit_last))
        else $error("blocked pick changed");

    // the walk stays clamped to the last particle
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.chosen_index <= INDEX_W'(PARTICLE_CNT - 1)))
        else $error("chosen index out of range");

endmodule

// File: rtl/lvr_weight_mem.sv
module lvr_weight_mem
    import lvr_pkg::*;
#(
    parameter int DEPTH  = PARTICLE_CNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [WEIGHT_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [WEIGHT_W-1:0] o_rdata
);

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [WEIGHT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lvr_walker.sv
module lvr_walker
    import lvr_pkg::*;
#(
    parameter int PARTICLE_CNT = PARTICLE_CNT_DEF,
    parameter int IDX_W        = $clog2(PARTICLE_CNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // load side
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [OFFSET_W-1:0] i_offset,
    // emit side
    output logic                o_emit_valid,
    input  logic                i_emit_ok,
    output logic [IDX_W-1:0]    o_emit_index,
    output logic                o_emit_last,
    // weight memory
    output logic                o_mem_we,
    output logic [IDX_W-1:0]    o_mem_waddr,
    output logic [WEIGHT_W-1:0] o_mem_wdata,
    output logic [IDX_W-1:0]    o_mem_raddr,
    input  logic [WEIGHT_W-1:0] i_mem_rdata
);

    localparam int CNT_W  = $clog2(PARTICLE_CNT + 1);
    localparam int CSUM_W = WEIGHT_W + 2 * CNT_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(PARTICLE_CNT - 1);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_m, n_m;
    logic [CSUM_W-1:0]   r_csum, n_csum;
    logic [CSUM_W-1:0]   r_point, n_point;

    logic                accept;
    logic                load_last;
    logic                advance;
    logic                emit;
    logic                emit_take;
    logic [CSUM_W-1:0]   w_scaled;

    assign accept    = (r_state == ST_LOAD) && i_valid;
    assign load_last = (r_load_cnt == LAST);
    assign advance   = (r_point > r_csum) && (r_idx != LAST);
    assign emit      = (r_state == ST_WALK) && !advance;
    assign emit_take = emit && i_emit_ok;
    // weights enter the running sum scaled by N, matching the scaled points
    assign w_scaled  = CSUM_W'(i_mem_rdata) * CSUM_W'(PARTICLE_CNT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && load_last) n_state = ST_PRIME;
            end
            ST_PRIME: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (emit_take && (r_m == LAST)) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_load_cnt = r_load_cnt;
        n_idx      = r_idx;
        n_m        = r_m;
        n_csum     = r_csum;
        n_point    = r_point;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_load_cnt = load_last ? '0 : r_load_cnt + 1'b1;
                    if (load_last) begin
                        n_point = CSUM_W'(i_offset) * CSUM_W'(PARTICLE_CNT);
                        n_csum  = '0;
                        n_idx   = '0;
                        n_m     = '0;
                    end
                end
            end
            ST_PRIME: begin
                n_csum = w_scaled;
            end
            ST_WALK: begin
                if (advance) begin
                    n_csum = r_csum + w_scaled;
                    n_idx  = r_idx + 1'b1;
                end else if (i_emit_ok) begin
                    n_point = r_point + CSUM_W'(Q16_ONE);
                    n_m     = (r_m == LAST) ? '0 : r_m + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // read data tracks the entry after the current index (the last entry once the index reaches it, weight 0 for prime)
    always_comb begin
        if (n_state == ST_PRIME) begin
            o_mem_raddr = '0;
        end else if (n_idx == LAST) begin
            o_mem_raddr = n_idx;
        end else begin
            o_mem_raddr = n_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_m     <= n_m;
        r_csum  <= n_csum;
        r_point <= n_point;
    end

    assign o_ready      = (r_state == ST_LOAD);
    assign o_emit_valid = emit;
    assign o_emit_index = r_idx;
    assign o_emit_last  = (r_m == LAST);
    assign o_mem_we     = accept;
    assign o_mem_waddr  = r_load_cnt;
    assign o_mem_wdata  = i_weight;

endmodule

// File: tb/sv/tb_low_variance_resampler.sv
module tb_low_variance_resampler
    import lvr_pkg::*;
();

    localparam int N          = PARTICLE_CNT_DEF;
    localparam int RAND_RUNS  = 4;
    localparam int HOLD_CYC   = 400;
    localparam int CYCLE_CAP  = 300000;
    localparam int DRAIN_CYC  = 20;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [OFFSET_W-1:0] offset;
    } t_weight_req;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_pick;

    logic clk;
    logic rst_n;

    lvr_in_if  in_ch ();
    lvr_out_if out_ch ();

    low_variance_resampler #(
        .PARTICLE_CNT(N)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_weight_req         pending_reqs [$];
    t_pick               expected_picks [$];
    logic [WEIGHT_W-1:0] run_weights [N];

    // predictor state
    logic [WEIGHT_W-1:0] weight_copy [N];
    int                  loaded;

    bit in_taken;
    bit out_taken;
    bit hold_off;
    bit tx_calm;
    bit rx_calm;
    int tx_wait;
    int rx_wait;
    int in_accepted;
    int errors;
    int cycle_cnt;

    function automatic int gap_draw(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // offset only matters on the final weight; the rest carry noise
    task automatic push_run(logic [OFFSET_W-1:0] offset);
        t_weight_req req;
        for (int i = 0; i < N; i++) begin
            req.weight = run_weights[i];
            req.offset = (i == N - 1) ? offset : OFFSET_W'($urandom_range(0, 1023));
            pending_reqs = {pending_reqs, req};
        end
    endtask

    task automatic queue_random_run();
        int unsigned     raw [N];
        longint unsigned total;
        longint unsigned acc;
        int              kind;
        kind  = $urandom_range(0, 9);
        total = 0;
        for (int i = 0; i < N; i++) begin
            if (kind >= 5 && kind <= 6)
                raw[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1000) : 0;
            else
                raw[i] = $urandom_range(0, 1000);
            total += raw[i];
        end
        if (total == 0) begin
            raw[$urandom_range(0, N - 1)] = 1;
            total = 1;
        end
        if (kind >= 8) begin
            // noise: arbitrary 17-bit weights, sums well above 1.0
            for (int i = 0; i < N; i++)
                run_weights[i] = WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
        end else begin
            acc = 0;
            for (int i = 0; i < N; i++) begin
                run_weights[i] = WEIGHT_W'((longint'(raw[i]) * Q16_ONE) / total);
                acc += run_weights[i];
            end
            // put the rounding remainder somewhere so the sum is exactly 1.0
            begin
                int pos;
                pos = $urandom_range(0, N - 1);
                run_weights[pos] = run_weights[pos] + WEIGHT_W'(Q16_ONE - acc);
            end
            if (kind == 7) begin
                // short total: late points run off the end and clamp
                for (int i = 0; i < N; i++)
                    run_weights[i] = run_weights[i] >> $urandom_range(1, 3);
            end
        end
        push_run(OFFSET_W'($urandom_range(0, 1023)));
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input acceptance, prediction and output check
    always @(posedge clk) begin : monitor
        int              slot;
        int              idx;
        longint unsigned csum;
        longint unsigned point;
        longint unsigned off;
        t_pick           pick;
        t_pick           want;
        in_taken  = in_ch.valid && in_ch.ready;
        out_taken = out_ch.valid && out_ch.ready;
        if (in_taken) begin
            in_accepted <= in_accepted + 1;
            slot = loaded;
            weight_copy[slot] = in_ch.weight;
            if (slot == N - 1) begin
                loaded = 0;
                off    = in_ch.start_offset;
                csum   = longint'(weight_copy[0]) * N;
                idx    = 0;
                for (int m = 0; m < N; m++) begin
                    point = off * N + longint'(m) * Q16_ONE;
                    while (point > csum && idx < N - 1) begin
                        idx++;
                        csum += longint'(weight_copy[idx]) * N;
                    end
                    pick.index = idx[INDEX_W-1:0];
                    pick.last  = (m == N - 1);
                    expected_picks = {expected_picks, pick};
                end
            end else begin
                loaded = slot + 1;
            end
        end
        if (out_taken) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected pick: index %0d last %0b", $time,
                         out_ch.chosen_index, out_ch.final_pick);
                errors++;
            end else begin
                want = expected_picks.pop_front();
                if (out_ch.chosen_index !== want.index ||
                    out_ch.final_pick !== want.last) begin
                    $display({"%0t: pick mismatch: expected index %0d last %0b, ",
                              "got index %0d last %0b"},
                             $time, want.index, want.last, out_ch.chosen_index,
                             out_ch.final_pick);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge clk) begin : driver
        bit          offering;
        t_weight_req req;
        offering = in_ch.valid;
        if (offering && in_taken) begin
            offering = 1'b0;
            tx_wait  = gap_draw(tx_calm);
            if ($urandom_range(0, 31) == 0)
                tx_calm = ~tx_calm;
        end
        if (!offering && rst_n) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (pending_reqs.size() > 0) begin
                req = pending_reqs.pop_front();
                in_ch.weight       <= req.weight;
                in_ch.start_offset <= req.offset;
                offering = 1'b1;
            end
        end
        in_ch.valid <= offering;
    end

    // result receiver
    always @(negedge clk) begin : receiver
        bit rdy;
        if (out_taken) begin
            rx_wait = gap_draw(rx_calm);
            if ($urandom_range(0, 31) == 0)
                rx_calm = ~rx_calm;
        end
        if (!rst_n || hold_off) begin
            rdy = 1'b0;
        end else if (rx_wait > 0) begin
            rdy = 1'b0;
            rx_wait--;
        end else begin
            rdy = 1'b1;
        end
        out_ch.ready <= rdy;
    end

    // long back-pressure during one walk so the input side stalls too
    initial begin : hold_process
        int held;
        hold_off = 1'b0;
        while (in_accepted < 5 * N)
            @(posedge clk);
        hold_off = 1'b1;
        held = 0;
        while (held < HOLD_CYC) begin
            @(posedge clk);
            held++;
        end
        hold_off = 1'b0;
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_CAP) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("low_variance_resampler regression: fail");
        $finish;
    end

    initial begin : sequencer
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.weight       = '0;
        in_ch.start_offset = '0;
        out_ch.ready       = 1'b0;
        in_taken           = 1'b0;
        out_taken          = 1'b0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        tx_wait            = 0;
        rx_wait            = 0;
        in_accepted        = 0;
        loaded             = 0;
        errors             = 0;

        // all zero weights, zero offset: first pick stays, rest clamp to the end
        for (int i = 0; i < N; i++)
            run_weights[i] = '0;
        push_run('0);

        // everything on particle 0, largest offset
        run_weights[0] = WEIGHT_W'(Q16_ONE);
        push_run('1);

        // flat weights, last one at the field maximum (above 1.0)
        for (int i = 0; i < N; i++)
            run_weights[i] = WEIGHT_W'(Q16_ONE / N);
        run_weights[N - 1] = '1;
        push_run('1);

        for (int r = 0; r < RAND_RUNS; r++)
            queue_random_run();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_ch.valid)
            @(posedge clk);
        while (expected_picks.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (errors == 0)
            $display("low_variance_resampler regression: pass");
        else
            $display("low_variance_resampler regression: fail");
        $finish;
    end

endmodule
